// ===== rtl/core/l2s_pkg.sv =====
// Shared constants, threshold types and elaboration-time table builders for the sRGB pixel packer.
package l2s_pkg;

  // Default and limit for the input channel width
  localparam int unsigned ChannelWidth = 16;
  // Threshold entry width, wide enough for 1.0 + 1 at the widest channel
  localparam int unsigned ThrW = 24;
  // Byte width and number of codes per byte
  localparam int unsigned ByteW = 8;
  localparam int unsigned NumCodes = 256;
  // Wide scratch width for the exact power compare
  localparam int unsigned BigW = 320;

  // Table select codes
  localparam logic [1:0] SEL_POW  = 2'd0;
  localparam logic [1:0] SEL_SQRT = 2'd1;
  localparam logic [1:0] SEL_LIN  = 2'd2;

  typedef logic [ThrW-1:0] thr_tbl_t [NumCodes];
  typedef logic [BigW-1:0] big_t;

  // Integer power on wide vectors
  function automatic big_t big_pow(big_t b, int unsigned e);
    big_t r;
    r = big_t'(1);
    for (int unsigned i = 0; i < e; i++) begin
      r = r * b;
    end
    return r;
  endfunction

  // Floor quotient on wide vectors, restoring shift and subtract
  function automatic big_t big_div(big_t n, big_t d);
    big_t q;
    big_t r;
    q = '0;
    r = '0;
    for (int i = BigW - 1; i >= 0; i--) begin
      r = {r[BigW-2:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // True when x^5 * 10761^12 >= one^5 * (40k+541)^12
  function automatic logic pow_at_least(big_t x, big_t one, int unsigned k);
    big_t lhs;
    big_t rhs;
    lhs = big_pow(x, 5) * big_pow(big_t'(10761), 12);
    rhs = big_pow(one, 5) * big_pow(big_t'(40 * k + 541), 12);
    return lhs >= rhs;
  endfunction

  // Smallest linear value whose byte reaches k, capped at one + 1 (never reached)
  function automatic thr_tbl_t build_table(logic [1:0] sel, int unsigned width);
    thr_tbl_t t;
    big_t one;
    big_t lo;
    big_t hi;
    big_t mid;
    big_t v;
    one = big_t'(1) << (width - 2);
    for (int unsigned k = 0; k < NumCodes; k++) begin
      v = '0;
      if (k != 0) begin
        case (sel)
          SEL_POW: begin
            lo = '0;
            hi = one + 1;
            for (int unsigned i = 0; i < 30; i++) begin
              if (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (pow_at_least(mid, one, k)) hi = mid;
                else lo = mid + 1;
              end
            end
            v = lo;
          end
          SEL_SQRT: begin
            v = big_div(one * big_t'((40 * k + 541) * (40 * k + 541)) + big_t'(115799120),
                        big_t'(115799121));
          end
          default: begin
            v = big_div(big_t'(100 * k - 50) * one + big_t'(329459), big_t'(329460));
          end
        endcase
        if (v > one + 1) v = one + 1;
      end
      t[k] = v[ThrW-1:0];
    end
    return t;
  endfunction

  // Smallest value on the power-law side of the linear segment
  function automatic logic [ThrW-1:0] lin_limit(int unsigned width);
    big_t one;
    big_t v;
    one = big_t'(1) << (width - 2);
    v = big_div(big_t'(31308) * one + big_t'(9999999), big_t'(10000000));
    return v[ThrW-1:0];
  endfunction

endpackage

// ===== rtl/core/l2s_lane.sv =====
// One colour lane: clamp, pick a curve, then a pipelined bit-by-bit threshold search.
module l2s_lane #(
  parameter int unsigned ChannelWidth = l2s_pkg::ChannelWidth
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          curve_i,
  input  logic [ChannelWidth-1:0]       chan_i,
  output logic [l2s_pkg::ByteW-1:0]     byte_o
);

  localparam int unsigned XW = ChannelWidth - 1;
  localparam int unsigned NStg = l2s_pkg::ByteW;
  localparam logic [XW-1:0] One = XW'(1) << (ChannelWidth - 2);
  localparam l2s_pkg::thr_tbl_t TblPow  = l2s_pkg::build_table(l2s_pkg::SEL_POW, ChannelWidth);
  localparam l2s_pkg::thr_tbl_t TblSqrt = l2s_pkg::build_table(l2s_pkg::SEL_SQRT, ChannelWidth);
  localparam l2s_pkg::thr_tbl_t TblLin  = l2s_pkg::build_table(l2s_pkg::SEL_LIN, ChannelWidth);
  localparam logic [l2s_pkg::ThrW-1:0] LinLimit = l2s_pkg::lin_limit(ChannelWidth);

  logic [XW-1:0]                x_d;
  logic [l2s_pkg::ThrW-1:0]     xw;
  logic [1:0]                   sel_d;
  logic [XW-1:0]                x_q   [NStg+1];
  logic [1:0]                   sel_q [NStg+1];
  logic [l2s_pkg::ByteW-1:0]    pre_q [NStg+1];
  logic [l2s_pkg::ByteW-1:0]    pre_d [NStg+1];

  // Clamp to 0..1 and choose the segment
  always_comb begin
    if (chan_i[ChannelWidth-1]) x_d = '0;
    else if (chan_i[XW-1:0] > One) x_d = One;
    else x_d = chan_i[XW-1:0];
    xw = {{(l2s_pkg::ThrW-XW){1'b0}}, x_d};
    if (xw < LinLimit) sel_d = l2s_pkg::SEL_LIN;
    else if (curve_i) sel_d = l2s_pkg::SEL_SQRT;
    else sel_d = l2s_pkg::SEL_POW;
  end

  // One result bit per stage, most significant first
  always_comb begin
    logic [l2s_pkg::ByteW-1:0]  cand;
    logic [l2s_pkg::ThrW-1:0]   thr;
    logic [l2s_pkg::ThrW-1:0]   xe;
    pre_d[0] = '0;
    for (int unsigned s = 1; s <= NStg; s++) begin
      cand = pre_q[s-1] | (l2s_pkg::ByteW'(1) << (NStg - s));
      xe = {{(l2s_pkg::ThrW-XW){1'b0}}, x_q[s-1]};
      case (sel_q[s-1])
        l2s_pkg::SEL_POW:  thr = TblPow[cand];
        l2s_pkg::SEL_SQRT: thr = TblSqrt[cand];
        default:           thr = TblLin[cand];
      endcase
      pre_d[s] = (xe >= thr) ? cand : pre_q[s-1];
    end
  end

  // Search pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= x_d;
      sel_q[0] <= sel_d;
      pre_q[0] <= pre_d[0];
      for (int unsigned s = 1; s <= NStg; s++) begin
        x_q[s]   <= x_q[s-1];
        sel_q[s] <= sel_q[s-1];
        pre_q[s] <= pre_d[s];
      end
    end
  end

  assign byte_o = pre_q[NStg];

endmodule

// ===== rtl/core/linear_to_srgb_pixel_pack.sv =====
// Top level: three sRGB lanes, alpha path, pixel merge and stream handshake.
//
// Usage: one linear RGBA pixel enters on the s_axis channel per item, tdata
// holding red, green, blue, alpha (each ChannelWidth bits, signed Q1.F) from
// the lowest bit up. One packed 32-bit pixel leaves on m_axis per item, alpha
// in the top byte, then blue, green, red. cfg_we_i/cfg_wdata_i set the curve:
// 0 exact 2.4 power, 1 square-root form; write only while idle.
// The pipeline has 9 register stages: one clamp stage and eight search stages,
// one result bit each, the last stage being the output register. Throughput
// is one pixel every cycle while the receiver does not stall; each search
// stage reads one entry of a constant threshold table.
// The whole pipeline moves as one: when the receiver stalls with a result
// waiting, every stage holds and s_axis_tready drops; it rises again as soon
// as the result is taken. Reset empties the pipeline and selects the power
// curve; no clearing pass is needed.
module linear_to_srgb_pixel_pack #(
  parameter int unsigned ChannelWidth = l2s_pkg::ChannelWidth,
  localparam int unsigned DataW = ((4 * ChannelWidth + 7) / 8) * 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // red_linear, green_linear, blue_linear, alpha_linear, zero fill
  input  logic [DataW-1:0]                      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // packed_pixel
  output logic [31:0]                           m_axis_tdata,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_wdata_i
);

  localparam int unsigned NStg = l2s_pkg::ByteW + 1;
  localparam int unsigned XW = ChannelWidth - 1;
  localparam logic [XW-1:0] One = XW'(1) << (ChannelWidth - 2);

  logic                       curve_select_q;
  logic [NStg-1:0]            vld_q;
  logic                       adv;
  logic [ChannelWidth-1:0]    chan [4];
  logic [l2s_pkg::ByteW-1:0]  col_byte [3];
  logic [XW-1:0]              ax;
  logic [XW+9:0]              asum;
  logic [l2s_pkg::ByteW-1:0]  abyte_d;
  logic [l2s_pkg::ByteW-1:0]  abyte_q [NStg];

  // Pipeline advances unless the output is full and stalled
  assign adv = !vld_q[NStg-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NStg-1];

  // Curve register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_select_q <= 1'b0;
    end else if (cfg_we_i) begin
      curve_select_q <= cfg_wdata_i;
    end
  end

  // Valid bits follow the data stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid};
    end
  end

  // Unpack the channels
  always_comb begin
    for (int unsigned c = 0; c < 4; c++) begin
      chan[c] = s_axis_tdata[c*ChannelWidth +: ChannelWidth];
    end
  end

  // Colour lanes
  for (genvar c = 0; c < 3; c++) begin : g_lane
    l2s_lane #(
      .ChannelWidth(ChannelWidth)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .curve_i(curve_select_q),
      .chan_i (chan[c]),
      .byte_o (col_byte[c])
    );
  end

  // Alpha: clamp and scale by 255 with round half up
  always_comb begin
    if (chan[3][ChannelWidth-1]) ax = '0;
    else if (chan[3][XW-1:0] > One) ax = One;
    else ax = chan[3][XW-1:0];
    asum = (XW+10)'(ax) * (XW+10)'(510) + (XW+10)'(One);
    abyte_d = 8'(asum >> (ChannelWidth - 1));
  end

  // Alpha delay line matching the lane latency
  always_ff @(posedge clk_i) begin
    if (adv) begin
      abyte_q[0] <= abyte_d;
      for (int unsigned s = 1; s < NStg; s++) begin
        abyte_q[s] <= abyte_q[s-1];
      end
    end
  end

  // Merge lanes into the output word
  assign m_axis_tdata = {abyte_q[NStg-1], col_byte[2], col_byte[1], col_byte[0]};

  // Input is taken exactly when the output stage can move
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output stall");

  // A stalled result keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled pixel changed");

  // A result appears only after an item reached the stage before output
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[NStg-2]))
    else $error("result without a source item");

endmodule
